// ----- rtl/mct_pkg.sv -----
// ============================================================================
// mct_pkg: shared types and constants for the multi countdown timer
// Event and mode codes, time-of-day limits and the transaction structs that
// travel on the command and result channels.
// ============================================================================
package mct_pkg;

    // Timer bank size and index width (index width fixed by the result field)
    localparam int NUM_TIMERS = 5;
    localparam int TIMER_W    = 3;

    // Serial load frame markers and field limits
    localparam logic [7:0] FRAME_HDR  = 8'hAA;
    localparam logic [7:0] FRAME_CMD  = 8'h01;
    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] MINSEC_MAX = 8'd59;

    // Input event codes
    typedef enum logic [2:0] {
        FN_TICK        = 3'd0,
        FN_NEXT        = 3'd1,
        FN_SET_PRESS   = 3'd2,
        FN_SET_LONG    = 3'd3,
        FN_INC         = 3'd4,
        FN_START_PRESS = 3'd5,
        FN_START_LONG  = 3'd6,
        FN_LOAD        = 3'd7
    } func_t;

    // Per-timer mode codes
    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_SETTING = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_PAUSED  = 2'd3
    } mode_t;

    // Edit field codes
    typedef enum logic [1:0] {
        FIELD_HOURS   = 2'd0,
        FIELD_MINUTES = 2'd1,
        FIELD_SECONDS = 2'd2
    } field_t;

    typedef logic [TIMER_W-1:0] timer_idx_t;

    typedef struct packed {
        logic [7:0] h;
        logic [7:0] m;
        logic [7:0] s;
    } hms_t;

    // Command transaction
    typedef struct packed {
        func_t      func;
        logic [7:0] frame_header;
        logic [7:0] frame_command;
        logic [7:0] load_hours;
        logic [7:0] load_minutes;
        logic [7:0] load_seconds;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        timer_idx_t timer_index;
        field_t     field_position;
        mode_t      mode;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic       alarm_led;
    } res_t;

endpackage

// ----- rtl/mct_core.sv -----
// ============================================================================
// mct_core: timer state and single-pass event update
// Holds the live time, the stored times, the per-timer modes, the selection,
// the edit field and the LED, and applies one event per enabled cycle.
// ============================================================================
module mct_core
    import mct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  cmd_t cmd,
    output res_t result
);

    hms_t       live_reg;
    hms_t       stored_reg [NUM_TIMERS];
    mode_t      mode_reg   [NUM_TIMERS];
    mode_t      cur_mode_reg;
    timer_idx_t sel_reg;
    field_t     field_reg;
    logic       led_reg;

    hms_t       live_next;
    mode_t      mode_next;
    timer_idx_t sel_next;
    field_t     field_next;
    logic       led_next;
    logic       store_we;
    hms_t       store_wd;
    logic       next_taken;

    timer_idx_t k_next;
    timer_idx_t rd_addr;
    hms_t       stored_rd;
    mode_t      next_mode_rd;
    hms_t       live_dec;
    hms_t       live_inc;
    hms_t       live_bump;
    logic       live_zero;

    // Pick the neighbour timer and the single stored-time read port
    assign k_next       = (sel_reg == timer_idx_t'(NUM_TIMERS - 1)) ? '0
                                                                    : sel_reg + timer_idx_t'(1);
    assign rd_addr      = (cmd.func == FN_NEXT) ? k_next : sel_reg;
    assign stored_rd    = stored_reg[rd_addr];
    assign next_mode_rd = mode_reg[k_next];
    assign live_zero    = (live_reg == '0);

    // Count down with borrow across the fields
    always_comb
    begin
        live_dec = live_reg;
        if (live_reg.s != 8'd0)
        begin
            live_dec.s = live_reg.s - 8'd1;
        end
        else if (live_reg.m != 8'd0)
        begin
            live_dec.m = live_reg.m - 8'd1;
            live_dec.s = MINSEC_MAX;
        end
        else
        begin
            live_dec.h = live_reg.h - 8'd1;
            live_dec.m = MINSEC_MAX;
            live_dec.s = MINSEC_MAX;
        end
    end

    // Bump the edited field, then wrap every field that is out of range
    always_comb
    begin
        live_inc = live_reg;
        case (field_reg)
            FIELD_HOURS:   live_inc.h = live_reg.h + 8'd1;
            FIELD_MINUTES: live_inc.m = live_reg.m + 8'd1;
            FIELD_SECONDS: live_inc.s = live_reg.s + 8'd1;
            default:       live_inc = live_reg;
        endcase
        live_bump   = live_inc;
        if (live_inc.h > HOUR_MAX)
        begin
            live_bump.h = 8'd0;
        end
        if (live_inc.m > MINSEC_MAX)
        begin
            live_bump.m = 8'd0;
        end
        if (live_inc.s > MINSEC_MAX)
        begin
            live_bump.s = 8'd0;
        end
    end

    // Decode the event against the selected timer's mode
    always_comb
    begin
        live_next  = live_reg;
        mode_next  = cur_mode_reg;
        sel_next   = sel_reg;
        field_next = field_reg;
        led_next   = led_reg;
        store_we   = 1'b0;
        store_wd   = live_reg;
        next_taken = 1'b0;
        unique case (cmd.func)
            FN_TICK:
            begin
                if (cur_mode_reg == MODE_RUNNING)
                begin
                    if (!live_zero)
                    begin
                        live_next = live_dec;
                    end
                    else
                    begin
                        mode_next = MODE_STANDBY;
                        led_next  = 1'b1;
                    end
                end
            end
            FN_NEXT:
            begin
                if (cur_mode_reg == MODE_STANDBY || cur_mode_reg == MODE_PAUSED)
                begin
                    next_taken = 1'b1;
                    sel_next   = k_next;
                    live_next  = stored_rd;
                    mode_next  = next_mode_rd;
                end
            end
            FN_SET_PRESS:
            begin
                if (cur_mode_reg == MODE_SETTING)
                begin
                    case (field_reg)
                        FIELD_HOURS:   field_next = FIELD_MINUTES;
                        FIELD_MINUTES: field_next = FIELD_SECONDS;
                        default:       field_next = FIELD_HOURS;
                    endcase
                end
                else
                begin
                    live_next = stored_rd;
                    mode_next = MODE_SETTING;
                    led_next  = 1'b0;
                end
            end
            FN_SET_LONG:
            begin
                if (cur_mode_reg == MODE_SETTING)
                begin
                    store_we  = 1'b1;
                    store_wd  = live_reg;
                    mode_next = MODE_STANDBY;
                end
            end
            FN_INC:
            begin
                if (cur_mode_reg == MODE_SETTING)
                begin
                    live_next = live_bump;
                end
            end
            FN_START_PRESS:
            begin
                field_next = FIELD_HOURS;
                if (cur_mode_reg == MODE_SETTING)
                begin
                    mode_next = MODE_RUNNING;
                end
                else if (cur_mode_reg != MODE_RUNNING)
                begin
                    live_next = stored_rd;
                    mode_next = MODE_RUNNING;
                end
                else
                begin
                    mode_next = MODE_PAUSED;
                    store_we  = 1'b1;
                    store_wd  = live_reg;
                end
            end
            FN_START_LONG:
            begin
                mode_next  = MODE_STANDBY;
                field_next = FIELD_HOURS;
                live_next  = '0;
                store_we   = 1'b1;
                store_wd   = '0;
            end
            FN_LOAD:
            begin
                if (cmd.frame_header == FRAME_HDR && cmd.frame_command == FRAME_CMD &&
                    cur_mode_reg == MODE_RUNNING)
                begin
                    live_next = '{h: cmd.load_hours, m: cmd.load_minutes,
                                  s: cmd.load_seconds};
                    store_we  = 1'b1;
                    store_wd  = '{h: cmd.load_hours, m: cmd.load_minutes,
                                  s: cmd.load_seconds};
                end
            end
        endcase
    end

    // Commit the update; the selected mode is shadowed in cur_mode_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= '0;
            cur_mode_reg <= MODE_STANDBY;
            sel_reg      <= '0;
            field_reg    <= FIELD_HOURS;
            led_reg      <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                stored_reg[i] <= '0;
                mode_reg[i]   <= MODE_STANDBY;
            end
        end
        else if (fire)
        begin
            live_reg     <= live_next;
            cur_mode_reg <= mode_next;
            sel_reg      <= sel_next;
            field_reg    <= field_next;
            led_reg      <= led_next;
            if (!next_taken)
            begin
                mode_reg[sel_reg] <= mode_next;
            end
            if (store_we)
            begin
                stored_reg[sel_reg] <= store_wd;
            end
        end
    end

    // Present the post-update view
    always_comb
    begin
        result.timer_index    = sel_next;
        result.field_position = field_next;
        result.mode           = mode_next;
        result.hours          = live_next.h;
        result.minutes        = live_next.m;
        result.seconds        = live_next.s;
        result.alarm_led      = led_next;
    end

`ifndef NO_ASSERTIONS
    // Shadow mode must track the selected timer's entry
    a_mode_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        cur_mode_reg == mode_reg[sel_reg])
        else $error("mct_core: shadow mode out of step with selected timer");

    // Selection stays within the timer bank
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg < timer_idx_t'(NUM_TIMERS))
        else $error("mct_core: selected timer out of range");

    // Leaving running on a tick at zero must raise the LED
    a_expiry_led: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd.func == FN_TICK && cur_mode_reg == MODE_RUNNING && live_zero)
        |=> (led_reg && cur_mode_reg == MODE_STANDBY))
        else $error("mct_core: expiry did not set LED and standby");
`endif

endmodule

// ----- rtl/multi_countdown_timer.sv -----
// ============================================================================
// multi_countdown_timer: five countdown timers on one h:m:s display
// Top level: command register, event core and result register.
// ============================================================================
// Accepts one event transaction per clock while not stalled and returns exactly
// one result transaction per event, in order. The event is captured in the
// command register, applied to the timer state by the single-pass update in
// mct_core and captured in the result register. The command side keeps
// taking events while a result waits to be taken; it stalls only when both
// the command and result registers are full and the result side is stalling.
// Sustained rate is one event per cycle while the result side does not stall.
module multi_countdown_timer
    import mct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic cmd_vld_reg;
    cmd_t cmd_reg;
    logic res_vld_reg;
    res_t res_reg;
    logic advance;
    res_t core_res;

    // Move the held event into the core when the result slot frees up
    assign advance   = cmd_vld_reg && (!res_vld_reg || !res_stall);
    assign cmd_stall = cmd_vld_reg && !advance;
    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    mct_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .cmd    (cmd_reg),
        .result (core_res)
    );

    // Hold the command transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
        end
        else if (cmd_valid && !cmd_stall)
        begin
            cmd_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            cmd_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= '0;
        end
        else if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
    end

    // Hold the result transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

`ifndef NO_ASSERTIONS
    // Every event applied yields a result in the next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_vld_reg)
        else $error("multi_countdown_timer: applied event produced no result");
`endif

endmodule
